// ===== rtl/core/matrix_store_rotate_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Matrix store rotate engine: assertion macros
// Shared concurrent checks, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_STORE_ROTATE_ENGINE_ASSERT_SVH
`define MATRIX_STORE_ROTATE_ENGINE_ASSERT_SVH

// same-cycle implication
`define MSRE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MSRE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/msre_pkg.sv =====
// ----------------------------------------------------------------------------
// msre_pkg
// Types, codes and microcode program of the matrix store rotate engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package msre_pkg;

  localparam int DEF_MAX_DIM = 8;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int PC_W        = 6;

  // operation codes
  localparam logic [2:0] MODE_FILL    = 3'd0;
  localparam logic [2:0] MODE_READ    = 3'd1;
  localparam logic [2:0] MODE_WRITE   = 3'd2;
  localparam logic [2:0] MODE_SUM     = 3'd3;
  localparam logic [2:0] MODE_ROT_CW  = 3'd4;
  localparam logic [2:0] MODE_ROT_CCW = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOT_SQ = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_START = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP  = 2'd3;

  typedef enum logic [2:0] {ASEL_A, ASEL_B, ASEL_C, ASEL_D, ASEL_S} asel_t;
  typedef enum logic [1:0] {WSEL_ZERO, WSEL_VAL, WSEL_IN, WSEL_ROT} wsel_t;
  typedef enum logic [2:0] {
    CAP_NONE, CAP_T0, CAP_T1, CAP_T2, CAP_T3, CAP_ACC, CAP_RES
  } cap_t;
  typedef enum logic [1:0] {IOP_HOLD, IOP_CLR, IOP_INC, IOP_LOAD} iop_t;
  typedef enum logic [2:0] {JOP_HOLD, JOP_CLR, JOP_INC, JOP_LOAD, JOP_NEXT_ROW} jop_t;
  typedef enum logic [1:0] {VOP_HOLD, VOP_START, VOP_STEP} vop_t;
  typedef enum logic [1:0] {SOP_KEEP, SOP_INIT, SOP_SQ, SOP_RANGE} sop_t;
  typedef enum logic [3:0] {
    COND_NEVER, COND_ALWAYS, COND_DISPATCH, COND_NOT_SQ, COND_IDX_BAD,
    COND_FILL_EMPTY, COND_FILL_J_MORE, COND_FILL_I_MORE, COND_CLR_J_MORE,
    COND_CLR_I_MORE, COND_N_ZERO, COND_SUM_MORE, COND_ROT_SMALL,
    COND_ROT_J_MORE, COND_ROT_I_MORE
  } cond_t;

  typedef struct packed {
    asel_t           asel;
    logic            rd;
    logic            wr;
    wsel_t           wsel;
    cap_t            cap;
    iop_t            iop;
    jop_t            jop;
    vop_t            vop;
    sop_t            sop;
    logic            wait_in;
    logic            emit;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic       not_sq;
    logic       idx_bad;
    logic       fill_empty;
    logic       fill_j_more;
    logic       fill_i_more;
    logic       clr_j_more;
    logic       clr_i_more;
    logic       n_zero;
    logic       sum_more;
    logic       rot_small;
    logic       rot_j_more;
    logic       rot_i_more;
    logic       out_free;
    logic [2:0] mode;
  } flags_t;

  // program labels
  localparam logic [PC_W-1:0] PC_CLR       = PC_W'(0);
  localparam logic [PC_W-1:0] PC_CLR_ROW   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(2);
  localparam logic [PC_W-1:0] PC_DISP      = PC_W'(3);
  localparam logic [PC_W-1:0] PC_FILL      = PC_W'(4);
  localparam logic [PC_W-1:0] PC_FILL_LOOP = PC_W'(5);
  localparam logic [PC_W-1:0] PC_FILL_ROW  = PC_W'(6);
  localparam logic [PC_W-1:0] PC_FILL_END  = PC_W'(7);
  localparam logic [PC_W-1:0] PC_READ      = PC_W'(8);
  localparam logic [PC_W-1:0] PC_READ_ISS  = PC_W'(9);
  localparam logic [PC_W-1:0] PC_READ_CAP  = PC_W'(10);
  localparam logic [PC_W-1:0] PC_WRITE     = PC_W'(11);
  localparam logic [PC_W-1:0] PC_WRITE_ST  = PC_W'(12);
  localparam logic [PC_W-1:0] PC_ERR_RANGE = PC_W'(13);
  localparam logic [PC_W-1:0] PC_ERR_SQ    = PC_W'(14);
  localparam logic [PC_W-1:0] PC_SUM       = PC_W'(15);
  localparam logic [PC_W-1:0] PC_SUM_CHK   = PC_W'(16);
  localparam logic [PC_W-1:0] PC_SUM_ISS   = PC_W'(17);
  localparam logic [PC_W-1:0] PC_SUM_ACC   = PC_W'(18);
  localparam logic [PC_W-1:0] PC_SUM_END   = PC_W'(19);
  localparam logic [PC_W-1:0] PC_ROT       = PC_W'(20);
  localparam logic [PC_W-1:0] PC_ROT_CHK   = PC_W'(21);
  localparam logic [PC_W-1:0] PC_ROT_RA    = PC_W'(22);
  localparam logic [PC_W-1:0] PC_ROT_RB    = PC_W'(23);
  localparam logic [PC_W-1:0] PC_ROT_RC    = PC_W'(24);
  localparam logic [PC_W-1:0] PC_ROT_RD    = PC_W'(25);
  localparam logic [PC_W-1:0] PC_ROT_CAP   = PC_W'(26);
  localparam logic [PC_W-1:0] PC_ROT_WA    = PC_W'(27);
  localparam logic [PC_W-1:0] PC_ROT_WB    = PC_W'(28);
  localparam logic [PC_W-1:0] PC_ROT_WC    = PC_W'(29);
  localparam logic [PC_W-1:0] PC_ROT_WD    = PC_W'(30);
  localparam logic [PC_W-1:0] PC_ROT_ROW   = PC_W'(31);
  localparam logic [PC_W-1:0] PC_ROT_END   = PC_W'(32);
  localparam logic [PC_W-1:0] PC_DONE      = PC_W'(33);

  localparam ctl_t CTL_NOP = '{
    asel: ASEL_A, rd: 1'b0, wr: 1'b0, wsel: WSEL_ZERO, cap: CAP_NONE,
    iop: IOP_HOLD, jop: JOP_HOLD, vop: VOP_HOLD, sop: SOP_KEEP,
    wait_in: 1'b0, emit: 1'b0, cond: COND_NEVER, target: PC_CLR
  };

  function automatic logic [PC_W-1:0] mode_entry(input logic [2:0] mode);
    logic [PC_W-1:0] pc;
    unique case (mode)
      MODE_FILL:                 pc = PC_FILL;
      MODE_READ:                 pc = PC_READ;
      MODE_WRITE:                pc = PC_WRITE;
      MODE_SUM:                  pc = PC_SUM;
      MODE_ROT_CW, MODE_ROT_CCW: pc = PC_ROT;
      default:                   pc = PC_DONE;
    endcase
    return pc;
  endfunction

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = CTL_NOP;
    unique case (pc)
      PC_CLR: begin
        c.wr = 1'b1; c.wsel = WSEL_ZERO; c.jop = JOP_INC;
        c.cond = COND_CLR_J_MORE; c.target = PC_CLR;
      end
      PC_CLR_ROW: begin
        c.iop = IOP_INC; c.jop = JOP_CLR;
        c.cond = COND_CLR_I_MORE; c.target = PC_CLR;
      end
      PC_IDLE: begin
        c.wait_in = 1'b1; c.iop = IOP_CLR; c.jop = JOP_CLR; c.sop = SOP_INIT;
      end
      PC_DISP: begin
        c.cond = COND_DISPATCH;
      end
      PC_FILL: begin
        c.vop = VOP_START; c.cond = COND_FILL_EMPTY; c.target = PC_DONE;
      end
      PC_FILL_LOOP: begin
        c.wr = 1'b1; c.wsel = WSEL_VAL; c.vop = VOP_STEP; c.jop = JOP_INC;
        c.cond = COND_FILL_J_MORE; c.target = PC_FILL_LOOP;
      end
      PC_FILL_ROW: begin
        c.iop = IOP_INC; c.jop = JOP_CLR;
        c.cond = COND_FILL_I_MORE; c.target = PC_FILL_LOOP;
      end
      PC_FILL_END: begin
        c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_READ, PC_WRITE: begin
        c.iop = IOP_LOAD; c.jop = JOP_LOAD;
        c.cond = COND_IDX_BAD; c.target = PC_ERR_RANGE;
      end
      PC_READ_ISS: begin
        c.rd = 1'b1;
      end
      PC_READ_CAP: begin
        c.cap = CAP_RES; c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_WRITE_ST: begin
        c.wr = 1'b1; c.wsel = WSEL_IN; c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_ERR_RANGE: begin
        c.sop = SOP_RANGE; c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_ERR_SQ: begin
        c.sop = SOP_SQ; c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_SUM, PC_ROT: begin
        c.cond = COND_NOT_SQ; c.target = PC_ERR_SQ;
      end
      PC_SUM_CHK: begin
        c.cond = COND_N_ZERO; c.target = PC_DONE;
      end
      PC_SUM_ISS: begin
        c.asel = ASEL_S; c.rd = 1'b1;
      end
      PC_SUM_ACC: begin
        c.cap = CAP_ACC; c.iop = IOP_INC;
        c.cond = COND_SUM_MORE; c.target = PC_SUM_ISS;
      end
      PC_SUM_END, PC_ROT_END: begin
        c.cond = COND_ALWAYS; c.target = PC_DONE;
      end
      PC_ROT_CHK: begin
        c.cond = COND_ROT_SMALL; c.target = PC_DONE;
      end
      PC_ROT_RA: begin
        c.asel = ASEL_A; c.rd = 1'b1;
      end
      PC_ROT_RB: begin
        c.asel = ASEL_B; c.rd = 1'b1; c.cap = CAP_T0;
      end
      PC_ROT_RC: begin
        c.asel = ASEL_C; c.rd = 1'b1; c.cap = CAP_T1;
      end
      PC_ROT_RD: begin
        c.asel = ASEL_D; c.rd = 1'b1; c.cap = CAP_T2;
      end
      PC_ROT_CAP: begin
        c.cap = CAP_T3;
      end
      PC_ROT_WA: begin
        c.asel = ASEL_A; c.wr = 1'b1; c.wsel = WSEL_ROT;
      end
      PC_ROT_WB: begin
        c.asel = ASEL_B; c.wr = 1'b1; c.wsel = WSEL_ROT;
      end
      PC_ROT_WC: begin
        c.asel = ASEL_C; c.wr = 1'b1; c.wsel = WSEL_ROT;
      end
      PC_ROT_WD: begin
        c.asel = ASEL_D; c.wr = 1'b1; c.wsel = WSEL_ROT; c.jop = JOP_INC;
        c.cond = COND_ROT_J_MORE; c.target = PC_ROT_RA;
      end
      PC_ROT_ROW: begin
        c.iop = IOP_INC; c.jop = JOP_NEXT_ROW;
        c.cond = COND_ROT_I_MORE; c.target = PC_ROT_RA;
      end
      PC_DONE: begin
        c.emit = 1'b1; c.cond = COND_ALWAYS; c.target = PC_IDLE;
      end
      default: begin
        c.cond = COND_ALWAYS; c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/msre_ram.sv =====
// ----------------------------------------------------------------------------
// msre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module msre_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/msre_seq.sv =====
// ----------------------------------------------------------------------------
// msre_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_store_rotate_engine_assert.svh"

module msre_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  msre_pkg::flags_t flags,
  output msre_pkg::ctl_t   ctl,
  output logic            in_tready,
  output logic            accept,
  output logic            emit_fire
);

  logic [msre_pkg::PC_W-1:0] pc_r;
  logic [msre_pkg::PC_W-1:0] pc_nxt;
  logic                      cond_hit;

  assign ctl       = msre_pkg::ucode(pc_r);
  assign in_tready = ctl.wait_in;
  assign accept    = ctl.wait_in & in_tvalid;
  assign emit_fire = ctl.emit & flags.out_free;

  always_comb begin
    unique case (ctl.cond)
      msre_pkg::COND_ALWAYS:      cond_hit = 1'b1;
      msre_pkg::COND_NOT_SQ:      cond_hit = flags.not_sq;
      msre_pkg::COND_IDX_BAD:     cond_hit = flags.idx_bad;
      msre_pkg::COND_FILL_EMPTY:  cond_hit = flags.fill_empty;
      msre_pkg::COND_FILL_J_MORE: cond_hit = flags.fill_j_more;
      msre_pkg::COND_FILL_I_MORE: cond_hit = flags.fill_i_more;
      msre_pkg::COND_CLR_J_MORE:  cond_hit = flags.clr_j_more;
      msre_pkg::COND_CLR_I_MORE:  cond_hit = flags.clr_i_more;
      msre_pkg::COND_N_ZERO:      cond_hit = flags.n_zero;
      msre_pkg::COND_SUM_MORE:    cond_hit = flags.sum_more;
      msre_pkg::COND_ROT_SMALL:   cond_hit = flags.rot_small;
      msre_pkg::COND_ROT_J_MORE:  cond_hit = flags.rot_j_more;
      msre_pkg::COND_ROT_I_MORE:  cond_hit = flags.rot_i_more;
      default:                    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    priority if (ctl.wait_in && !in_tvalid) begin
      pc_nxt = pc_r;
    end else if (ctl.emit && !flags.out_free) begin
      pc_nxt = pc_r;
    end else if (ctl.cond == msre_pkg::COND_DISPATCH) begin
      pc_nxt = msre_pkg::mode_entry(flags.mode);
    end else if (cond_hit) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = pc_r + msre_pkg::PC_W'(1);
    end
  end

  // reset starts the store clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= msre_pkg::PC_CLR;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  `MSRE_ASSERT_NEXT(a_one_item_in_flight, accept, !in_tready, "beat taken while busy")
  `MSRE_ASSERT_IMP(a_pc_in_program, 1'b1, pc_r <= msre_pkg::PC_DONE, "step outside program")

endmodule

// ===== rtl/core/msre_dp.sv =====
// ----------------------------------------------------------------------------
// msre_dp
// Datapath: config registers, loop counters, address generation, store,
// temporaries and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "matrix_store_rotate_engine_assert.svh"

module msre_dp #(
  parameter int MAX_DIM = msre_pkg::DEF_MAX_DIM
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msre_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [31:0]                       cfg_wdata,
  input  logic                              accept,
  input  logic [msre_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  msre_pkg::ctl_t                    ctl,
  input  logic                              emit_fire,
  input  logic                              out_tready,
  output msre_pkg::flags_t                  flags,
  output logic                              out_tvalid,
  output logic [msre_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int SUM_W  = DIM_W + 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(int'(row) * MAX_DIM + int'(col));
  endfunction

  logic [3:0]            rows_r;
  logic [3:0]            cols_r;
  logic [31:0]           fill_start_r;
  logic [31:0]           fill_step_r;
  logic [2:0]            mode_r;
  logic [2:0]            row_in_r;
  logic [2:0]            col_in_r;
  logic [31:0]           wval_r;
  logic [IDX_W-1:0]      i_r, i_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [31:0]           val_r;
  logic [3:0][31:0]      t_r;
  logic [31:0]           result_r, result_nxt;
  logic [1:0]            status_r, status_nxt;
  logic                  out_valid_r;
  logic [msre_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [DIM_W-1:0]      nr, nc, nm1;
  logic [IDX_W-1:0]      rev_i, rev_j;
  logic [ADDR_W-1:0]     addr;
  logic [31:0]           wdata;
  logic [31:0]           rdata;
  logic [1:0]            asel_lo;
  logic [1:0]            rot_sel;
  logic                  rot_cw;
  logic                  out_free;

  // config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r       <= 4'd1;
      cols_r       <= 4'd1;
      fill_start_r <= '0;
      fill_step_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        msre_pkg::CFG_ROWS:  rows_r       <= cfg_wdata[3:0];
        msre_pkg::CFG_COLS:  cols_r       <= cfg_wdata[3:0];
        msre_pkg::CFG_START: fill_start_r <= cfg_wdata;
        msre_pkg::CFG_STEP:  fill_step_r  <= cfg_wdata;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= in_tdata[2:0];
      row_in_r <= in_tdata[5:3];
      col_in_r <= in_tdata[8:6];
      wval_r   <= in_tdata[40:9];
    end
  end

  // sizes saturate at MAX_DIM
  always_comb begin
    nr = (int'(rows_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(rows_r);
    nc = (int'(cols_r) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(cols_r);
    nm1   = nr - DIM_W'(1);
    rev_i = IDX_W'(nm1 - DIM_W'(i_r));
    rev_j = IDX_W'(nm1 - DIM_W'(j_r));
  end

  always_comb begin
    unique case (ctl.asel)
      msre_pkg::ASEL_A: addr = cell_addr(i_r, j_r);
      msre_pkg::ASEL_B: addr = cell_addr(rev_j, i_r);
      msre_pkg::ASEL_C: addr = cell_addr(rev_i, rev_j);
      msre_pkg::ASEL_D: addr = cell_addr(j_r, rev_i);
      msre_pkg::ASEL_S: addr = cell_addr(rev_i, i_r);
      default:          addr = cell_addr(i_r, j_r);
    endcase
  end

  // each corner takes the value of its neighbor along the turn
  assign rot_cw  = (mode_r == msre_pkg::MODE_ROT_CW);
  assign asel_lo = 2'(ctl.asel);
  assign rot_sel = rot_cw ? asel_lo + 2'd1 : asel_lo - 2'd1;

  always_comb begin
    unique case (ctl.wsel)
      msre_pkg::WSEL_ZERO: wdata = '0;
      msre_pkg::WSEL_VAL:  wdata = val_r;
      msre_pkg::WSEL_IN:   wdata = wval_r;
      msre_pkg::WSEL_ROT:  wdata = t_r[rot_sel];
    endcase
  end

  msre_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ctl.wr),
    .waddr(addr),
    .wdata(wdata),
    .re   (ctl.rd),
    .raddr(addr),
    .rdata(rdata)
  );

  // loop counters
  always_comb begin
    unique case (ctl.iop)
      msre_pkg::IOP_HOLD: i_nxt = i_r;
      msre_pkg::IOP_CLR:  i_nxt = '0;
      msre_pkg::IOP_INC:  i_nxt = i_r + IDX_W'(1);
      msre_pkg::IOP_LOAD: i_nxt = IDX_W'(row_in_r);
    endcase
    unique case (ctl.jop)
      msre_pkg::JOP_HOLD:     j_nxt = j_r;
      msre_pkg::JOP_CLR:      j_nxt = '0;
      msre_pkg::JOP_INC:      j_nxt = j_r + IDX_W'(1);
      msre_pkg::JOP_LOAD:     j_nxt = IDX_W'(col_in_r);
      msre_pkg::JOP_NEXT_ROW: j_nxt = i_r + IDX_W'(1);
      default:                j_nxt = j_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else begin
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
  end

  // fill value and temporaries
  always_ff @(posedge clk) begin
    unique case (ctl.vop)
      msre_pkg::VOP_START: val_r <= fill_start_r;
      msre_pkg::VOP_STEP:  val_r <= val_r + fill_step_r;
      default:             val_r <= val_r;
    endcase
    unique case (ctl.cap)
      msre_pkg::CAP_T0: t_r[0] <= rdata;
      msre_pkg::CAP_T1: t_r[1] <= rdata;
      msre_pkg::CAP_T2: t_r[2] <= rdata;
      msre_pkg::CAP_T3: t_r[3] <= rdata;
      default:          t_r    <= t_r;
    endcase
  end

  always_comb begin
    priority if (ctl.sop == msre_pkg::SOP_INIT) begin
      result_nxt = '0;
    end else if (ctl.cap == msre_pkg::CAP_ACC) begin
      result_nxt = result_r + rdata;
    end else if (ctl.cap == msre_pkg::CAP_RES) begin
      result_nxt = rdata;
    end else begin
      result_nxt = result_r;
    end
    unique case (ctl.sop)
      msre_pkg::SOP_KEEP:  status_nxt = status_r;
      msre_pkg::SOP_INIT:  status_nxt = msre_pkg::ST_OK;
      msre_pkg::SOP_SQ:    status_nxt = msre_pkg::ST_NOT_SQ;
      msre_pkg::SOP_RANGE: status_nxt = msre_pkg::ST_RANGE;
    endcase
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    status_r <= status_nxt;
  end

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_data_r <= {6'd0, status_r, result_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // condition flags
  always_comb begin
    flags.not_sq      = (nr != nc);
    flags.idx_bad     = (8'(row_in_r) >= 8'(nr)) || (8'(col_in_r) >= 8'(nc));
    flags.fill_empty  = (nr == '0) || (nc == '0);
    flags.fill_j_more = (DIM_W'(j_r) + DIM_W'(1)) < nc;
    flags.fill_i_more = (DIM_W'(i_r) + DIM_W'(1)) < nr;
    flags.clr_j_more  = (DIM_W'(j_r) + DIM_W'(1)) < DIM_W'(MAX_DIM);
    flags.clr_i_more  = (DIM_W'(i_r) + DIM_W'(1)) < DIM_W'(MAX_DIM);
    flags.n_zero      = (nr == '0);
    flags.sum_more    = (DIM_W'(i_r) + DIM_W'(1)) < nr;
    flags.rot_small   = nr < DIM_W'(2);
    flags.rot_j_more  = (SUM_W'(i_r) + SUM_W'(j_r) + SUM_W'(2)) < SUM_W'(nr);
    flags.rot_i_more  = (DIM_W'(i_r) + DIM_W'(1)) < (nr >> 1);
    flags.out_free    = out_free;
    flags.mode        = mode_r;
  end

  `MSRE_ASSERT_IMP(a_err_result_zero, emit_fire && status_r != msre_pkg::ST_OK, result_r == '0, "error with data")
  `MSRE_ASSERT_IMP(a_range_only_access, emit_fire && status_r == msre_pkg::ST_RANGE, mode_r == msre_pkg::MODE_READ || mode_r == msre_pkg::MODE_WRITE, "range error on wrong op")
  `MSRE_ASSERT_IMP(a_sq_err_shape, emit_fire && status_r == msre_pkg::ST_NOT_SQ, nr != nc, "square error on square matrix")

endmodule

// ===== rtl/core/matrix_store_rotate_engine.sv =====
// ----------------------------------------------------------------------------
// matrix_store_rotate_engine
// Integer matrix store with fill, entry access, anti-diagonal sum and
// in-place quarter-turn rotation, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One operation per input beat, one result beat per operation, one operation
// in flight. Every step goes through the single read and single write port
// of the MAX_DIM x MAX_DIM store, so the cost follows the entries visited:
// read and write touch one entry, fill each entry of the rows x cols area,
// the anti-diagonal sum its n entries, and rotation each group of four
// entries, ring by ring. After reset the store is swept to zero before the
// first beat is taken; config writes go in at any time the block is idle.
// A finished result sits in an output register, so the next beat is taken
// while it waits.
`timescale 1ns / 1ps

module matrix_store_rotate_engine #(
  parameter int MAX_DIM = msre_pkg::DEF_MAX_DIM
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] mode, [5:3] row_index, [8:6] col_index, [40:9] write_value
  input  logic [msre_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] result_value, [33:32] status
  output logic [msre_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                                cfg_we,
  input  logic [msre_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [31:0]                         cfg_wdata
);

  msre_pkg::ctl_t   ctl;
  msre_pkg::flags_t flags;
  logic             accept;
  logic             emit_fire;

  msre_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .flags    (flags),
    .ctl      (ctl),
    .in_tready(in_tready),
    .accept   (accept),
    .emit_fire(emit_fire)
  );

  msre_dp #(
    .MAX_DIM(MAX_DIM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_tdata  (in_tdata),
    .ctl       (ctl),
    .emit_fire (emit_fire),
    .out_tready(out_tready),
    .flags     (flags),
    .out_tvalid(out_tvalid),
    .out_tdata (out_tdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the matrix store rotate engine from its ports. The directed part
// walks a table: a reset readback, the value and size extremes, every
// operation, both error statuses, the unused modes and empty or oversized
// matrices. Random operations follow under changing register settings; most
// of them hit the matrix in use. Every result beat is compared in order with
// a table literal or a behavioral model of the store held here; both sides
// of the stream stall at random but for the last third of the random ops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import msre_pkg::*;

  localparam int MAX_DIM        = DEF_MAX_DIM;
  localparam int MAT_CELLS      = MAX_DIM * MAX_DIM;
  localparam int RANDOM_OPS     = 1650;
  localparam int OPS_PER_SET    = 50;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 200;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  status;
  } op_result_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_ADDR_W-1:0] reg_idx;
    logic [31:0]           reg_val;
    logic [2:0]            mode;
    logic [2:0]            row;
    logic [2:0]            col;
    logic [31:0]           wval;
    logic                  lit;
    logic [31:0]           lit_value;
    logic [1:0]            lit_status;
  } step_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [31:0]            cfg_wdata = '0;

  // model state
  logic [31:0] mat_model [MAT_CELLS];
  logic [3:0]  cur_rows = 4'd1;
  logic [3:0]  cur_cols = 4'd1;
  logic [31:0] cur_start = '0;
  logic [31:0] cur_step = '0;

  op_result_t pending_results [$];
  op_result_t oldest;
  int send_gap_pct = 23;
  int recv_stall_pct = 60;
  int ops_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  matrix_store_rotate_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic op_result_t apply_op(input logic [2:0] m, input logic [2:0] r,
                                          input logic [2:0] c, input logic [31:0] w);
    op_result_t  res;
    int unsigned nr;
    int unsigned nc;
    logic [31:0] v;
    logic [31:0] prev [MAT_CELLS];
    res.value = '0;
    res.status = ST_OK;
    nr = (cur_rows > MAX_DIM) ? MAX_DIM : cur_rows;
    nc = (cur_cols > MAX_DIM) ? MAX_DIM : cur_cols;
    case (m)
      MODE_FILL: begin
        v = cur_start;
        for (int y = 0; y < nr; y++) begin
          for (int x = 0; x < nc; x++) begin
            mat_model[y * MAX_DIM + x] = v;
            v = v + cur_step;
          end
        end
      end
      MODE_READ, MODE_WRITE: begin
        if (r >= nr || c >= nc) begin
          res.status = ST_RANGE;
        end else if (m == MODE_READ) begin
          res.value = mat_model[r * MAX_DIM + c];
        end else begin
          mat_model[r * MAX_DIM + c] = w;
        end
      end
      MODE_SUM: begin
        if (nr != nc) begin
          res.status = ST_NOT_SQ;
        end else begin
          for (int k = 0; k < nr; k++)
            res.value = res.value + mat_model[(nr - 1 - k) * MAX_DIM + k];
        end
      end
      MODE_ROT_CW, MODE_ROT_CCW: begin
        if (nr != nc) begin
          res.status = ST_NOT_SQ;
        end else begin
          prev = mat_model;
          for (int y = 0; y < nr; y++) begin
            for (int x = 0; x < nr; x++) begin
              if (m == MODE_ROT_CW) begin
                mat_model[y * MAX_DIM + x] = prev[(nr - 1 - x) * MAX_DIM + y];
              end else begin
                mat_model[y * MAX_DIM + x] = prev[x * MAX_DIM + nr - 1 - y];
              end
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic step_t op_row(input logic [2:0] m, input logic [2:0] r,
                                   input logic [2:0] c, input logic [31:0] w,
                                   input logic lit, input logic [31:0] lv,
                                   input logic [1:0] ls);
    step_t s;
    s = '0;
    s.mode = m;
    s.row = r;
    s.col = c;
    s.wval = w;
    s.lit = lit;
    s.lit_value = lv;
    s.lit_status = ls;
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ROWS:  cur_rows = val[3:0];
      CFG_COLS:  cur_cols = val[3:0];
      CFG_START: cur_start = val;
      CFG_STEP:  cur_step = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold off input and let every outstanding result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic push_op(input logic [2:0] m, input logic [2:0] r, input logic [2:0] c,
                         input logic [31:0] w, input logic lit,
                         input logic [31:0] lit_value, input logic [1:0] lit_status);
    op_result_t predicted;
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, w, c, r, m};
    do @(posedge clk); while (!in_tready);
    predicted = apply_op(m, r, c, w);
    if (lit) begin
      predicted.value = lit_value;
      predicted.status = lit_status;
    end
    pending_results.push_back(predicted);
    ops_sent++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[31:0] !== oldest.value) begin
          $display("%0t: result_value mismatch, expected %h actual %h",
                   $time, oldest.value, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[33:32] !== oldest.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, oldest.status, out_tdata[33:32]);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    step_t       plan [$];
    step_t       s;
    logic [3:0]  dr;
    logic [3:0]  dc;
    logic [31:0] sv;
    logic [2:0]  m;
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] w;
    int unsigned nr;
    int unsigned nc;
    int unsigned pick;

    foreach (mat_model[k]) mat_model[k] = '0;

    // reset state: 1 x 1 matrix of zero
    plan.push_back(op_row(MODE_READ, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd1, 3'd0, 32'h0, 1'b1, 32'h0, ST_RANGE));
    plan.push_back(op_row(MODE_SUM, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_SPARE6, 3'd7, 3'd7, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_SPARE7, 3'd0, 3'd0, 32'hffffffff, 1'b1, 32'h0, ST_OK));
    // full 8 x 8, fill wraps past the largest positive value
    plan.push_back(cfg_row(CFG_ROWS, 32'd8));
    plan.push_back(cfg_row(CFG_COLS, 32'd8));
    plan.push_back(cfg_row(CFG_START, 32'h7fffffff));
    plan.push_back(cfg_row(CFG_STEP, 32'd1));
    plan.push_back(op_row(MODE_FILL, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd0, 3'd0, 32'h0, 1'b1, 32'h7fffffff, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd0, 3'd1, 32'h0, 1'b1, 32'h80000000, ST_OK));
    plan.push_back(op_row(MODE_WRITE, 3'd7, 3'd7, 32'h80000000, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_SUM, 3'd0, 3'd0, 32'h0, 1'b0, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_ROT_CW, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd7, 3'd0, 32'h0, 1'b0, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_ROT_CCW, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd7, 3'd7, 32'h0, 1'b1, 32'h80000000, ST_OK));
    // 3 x 5: not square, column out of range
    plan.push_back(cfg_row(CFG_ROWS, 32'd3));
    plan.push_back(cfg_row(CFG_COLS, 32'd5));
    plan.push_back(op_row(MODE_SUM, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_NOT_SQ));
    plan.push_back(op_row(MODE_ROT_CW, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_NOT_SQ));
    plan.push_back(op_row(MODE_WRITE, 3'd2, 3'd5, 32'h1234, 1'b1, 32'h0, ST_RANGE));
    plan.push_back(op_row(MODE_FILL, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    // oversized dims saturate to 8 x 8
    plan.push_back(cfg_row(CFG_ROWS, 32'd15));
    plan.push_back(cfg_row(CFG_COLS, 32'd9));
    plan.push_back(cfg_row(CFG_START, 32'h80000000));
    plan.push_back(cfg_row(CFG_STEP, 32'hffffffff));
    plan.push_back(op_row(MODE_FILL, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_READ, 3'd7, 3'd7, 32'h0, 1'b0, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_ROT_CW, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    // empty matrix
    plan.push_back(cfg_row(CFG_ROWS, 32'd0));
    plan.push_back(cfg_row(CFG_COLS, 32'd0));
    plan.push_back(op_row(MODE_READ, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_RANGE));
    plan.push_back(op_row(MODE_SUM, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_ROT_CCW, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(op_row(MODE_FILL, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_OK));
    plan.push_back(cfg_row(CFG_COLS, 32'd3));
    plan.push_back(op_row(MODE_SUM, 3'd0, 3'd0, 32'h0, 1'b1, 32'h0, ST_NOT_SQ));

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < plan.size(); k++) begin
      s = plan[k];
      if (s.is_cfg) begin
        if (k == 0 || !plan[k - 1].is_cfg) begin
          settle();
          settings_used++;
        end
        write_reg(s.reg_idx, s.reg_val);
      end else begin
        push_op(s.mode, s.row, s.col, s.wval, s.lit, s.lit_value, s.lit_status);
      end
    end

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == RANDOM_OPS / 3) begin
        send_gap_pct = 60;
        recv_stall_pct = 23;
      end else if (i == 2 * RANDOM_OPS / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (i % OPS_PER_SET == 0) begin
        settle();
        settings_used++;
        pick = $urandom_range(99);
        if (pick < 70) begin
          dr = 4'($urandom_range(8, 1));
          if ($urandom_range(3) == 0) dr = 4'd8;
          dc = dr;
        end else if (pick < 85) begin
          dr = 4'($urandom_range(8, 1));
          dc = 4'($urandom_range(8, 1));
        end else begin
          dr = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
          dc = ($urandom_range(1) == 0) ? 4'($urandom_range(15)) : dr;
        end
        write_reg(CFG_ROWS, {28'd0, dr});
        write_reg(CFG_COLS, {28'd0, dc});
        case ($urandom_range(4))
          0: sv = 32'h0;
          1: sv = 32'h7fffffff;
          2: sv = 32'h80000000;
          3: sv = 32'hffffffff;
          default: sv = $urandom;
        endcase
        write_reg(CFG_START, sv);
        case ($urandom_range(6))
          0: sv = 32'h0;
          1: sv = 32'h1;
          2: sv = 32'hffffffff;
          3: sv = 32'h7fffffff;
          4: sv = 32'h80000000;
          5: sv = 32'($urandom_range(16));
          default: sv = $urandom;
        endcase
        write_reg(CFG_STEP, sv);
      end

      nr = (cur_rows > MAX_DIM) ? MAX_DIM : cur_rows;
      nc = (cur_cols > MAX_DIM) ? MAX_DIM : cur_cols;
      pick = $urandom_range(99);
      if (pick < 10)      m = MODE_FILL;
      else if (pick < 38) m = MODE_READ;
      else if (pick < 66) m = MODE_WRITE;
      else if (pick < 76) m = MODE_SUM;
      else if (pick < 84) m = MODE_ROT_CW;
      else if (pick < 92) m = MODE_ROT_CCW;
      else if (pick < 96) m = MODE_SPARE6;
      else                m = MODE_SPARE7;
      // mostly in-range indexes
      if (nr != 0 && nc != 0 && $urandom_range(99) < 85) begin
        r = 3'($urandom_range(nr - 1));
        c = 3'($urandom_range(nc - 1));
      end else begin
        r = 3'($urandom_range(7));
        c = 3'($urandom_range(7));
      end
      case ($urandom_range(9))
        0: w = 32'h7fffffff;
        1: w = 32'h80000000;
        2: w = ($urandom_range(1) == 0) ? 32'h0 : 32'hffffffff;
        default: w = $urandom;
      endcase
      push_op(m, r, c, w, 1'b0, 32'h0, ST_OK);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d operations and %0d result beats over %0d register settings",
             ops_sent, results_seen, settings_used);
    $display("Mismatches: %0d, results still outstanding: %0d",
             mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
